### rtl/cscan_disk_scheduler_macros.svh
// ----------------------------------------------------------------------------
// C-SCAN disk scheduler assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CSCAN_DISK_SCHEDULER_MACROS_SVH
`define CSCAN_DISK_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSCAN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSCAN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cscan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-SCAN scheduler package
// Widths, register indexes and types shared by the scheduler modules.
// ----------------------------------------------------------------------------
package cscan_pkg;

    localparam int TRACK_BITS    = 16;
    localparam int SEEK_BITS     = 18;
    localparam int SIZE_BITS     = TRACK_BITS + 1;
    localparam int IN_DATA_BITS  = ((TRACK_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((TRACK_BITS + SEEK_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_DISK_SIZE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_HEAD = 1'b1;

    localparam logic [SIZE_BITS-1:0] DISK_SIZE_RESET = SIZE_BITS'(200);

    typedef logic [TRACK_BITS-1:0] track_t;
    typedef logic [SEEK_BITS-1:0]  seek_t;

    localparam seek_t SEEK_MAX = '1;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

endpackage

### rtl/cscan_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-SCAN sorting cell
// One stage of the request chain: keeps the row sorted on insertion and
// shifts towards the head of the row while the schedule is read out.
// ----------------------------------------------------------------------------
module cscan_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  cscan_pkg::cell_ctl_t ctl,
    input  cscan_pkg::track_t   ins_key,
    input  cscan_pkg::track_t   prev_key,
    input  logic                prev_valid,
    input  logic                prev_gt,
    input  cscan_pkg::track_t   next_key,
    input  logic                next_valid,
    output cscan_pkg::track_t   key,
    output logic                valid,
    output logic                gt
);

    cscan_pkg::track_t key_reg;
    cscan_pkg::track_t key_next;
    logic              valid_reg;
    logic              valid_next;

    assign gt    = valid_reg && (key_reg > ins_key);
    assign key   = key_reg;
    assign valid = valid_reg;

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctl.shift) begin
            key_next   = next_key;
            valid_next = next_valid;
        end else if (ctl.insert && (!valid_reg || gt)) begin
            if (prev_gt) begin
                key_next   = prev_key;
                valid_next = 1'b1;
            end else if (prev_valid) begin
                key_next   = ins_key;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

### rtl/cscan_disk_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-SCAN disk scheduler
// Requests stream in on the s_ channel and are kept in a sorted row of cells.
// The transfer with s_tlast high closes the batch; the block then sends the
// C-SCAN service order on the m_ channel with the running seek total.
// Tracks above start_head come first in ascending order together with the
// disk end, then the head jumps to track 0 (costing disk_size - 1) and the
// tracks below start_head follow in ascending order. Requests equal to the
// head are dropped; requests beyond MAX_REQUESTS are dropped and every result
// of that batch carries the overflow flag in m_tuser.
// Loading takes one request per cycle. After the closing transfer the row is
// rotated once through all MAX_REQUESTS cells and then drained once; the
// first result is registered in the output register from the ST_UP state
// that follows the closing transfer at the earliest.
// s_tready is low while a schedule is being sent. A stalled receiver holds
// the output register and freezes the row whenever the next step has a
// result to send. Reset empties the row, sets disk_size to 200 and
// start_head to 0. The user must write the configuration port only while no
// schedule is pending; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "cscan_disk_scheduler_macros.svh"

module cscan_disk_scheduler #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [cscan_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cscan_pkg::SIZE_BITS-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: track_number.
    input  logic [cscan_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: visited_track, cumulative_seek, zero padding.
    output logic [cscan_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // Fields from bit 0: overflow_flag.
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);
    localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_REQUESTS);
    localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);
    localparam int PAD_BITS = cscan_pkg::OUT_DATA_BITS - cscan_pkg::TRACK_BITS
                              - cscan_pkg::SEEK_BITS;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_UP   = 3'd1;
    localparam logic [2:0] ST_END  = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_DOWN = 3'd4;

    logic [cscan_pkg::SIZE_BITS-1:0] disk_size_reg;
    cscan_pkg::track_t               start_head_reg;

    logic [2:0]          state_reg,    state_next;
    logic [CNT_BITS-1:0] req_reg,      req_next;
    logic [CNT_BITS-1:0] cnt_reg,      cnt_next;
    logic [CNT_BITS-1:0] left_reg,     left_next;
    logic                ovf_reg,      ovf_next;
    logic                end_done_reg, end_done_next;
    cscan_pkg::track_t   pos_reg,      pos_next;
    cscan_pkg::seek_t    seek_reg,     seek_next;

    logic              m_valid_reg;
    cscan_pkg::track_t m_track_reg;
    cscan_pkg::seek_t  m_seek_reg;
    logic              m_ovf_reg;
    logic              m_last_reg;

    cscan_pkg::track_t   cell_key   [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] cell_valid;
    logic [MAX_REQUESTS-1:0] cell_gt;
    cscan_pkg::cell_ctl_t cell_ctl;

    cscan_pkg::track_t end_track;
    cscan_pkg::track_t head;
    cscan_pkg::track_t k0;
    logic              v0;
    logic              in_xfer;
    logic              out_free;
    logic              close_batch;
    logic              emit;
    logic              emit_jump;
    logic              emit_last;
    logic              do_shift;
    logic              do_insert;
    logic              recirc;
    cscan_pkg::track_t emit_track;
    cscan_pkg::track_t seek_step;
    cscan_pkg::track_t addend;
    logic [cscan_pkg::SEEK_BITS:0] seek_sum;
    cscan_pkg::seek_t  seek_sat;

    assign head     = start_head_reg;
    assign k0       = cell_key[0];
    assign v0       = cell_valid[0];
    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        if (disk_size_reg == '0) begin
            end_track = '0;
        end else if (disk_size_reg[cscan_pkg::SIZE_BITS-1]) begin
            end_track = '1;
        end else begin
            end_track = disk_size_reg[cscan_pkg::TRACK_BITS-1:0] - cscan_pkg::track_t'(1);
        end
    end

    // Sorted row of cells; cell 0 holds the smallest track.
    assign cell_ctl.insert = do_insert;
    assign cell_ctl.shift  = do_shift;

    for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
        cscan_pkg::track_t prev_key_w;
        logic              prev_valid_w;
        logic              prev_gt_w;
        cscan_pkg::track_t next_key_w;
        logic              next_valid_w;

        if (i == 0) begin : g_first
            assign prev_key_w   = '0;
            assign prev_valid_w = 1'b1;
            assign prev_gt_w    = 1'b0;
        end else begin : g_inner
            assign prev_key_w   = cell_key[i-1];
            assign prev_valid_w = cell_valid[i-1];
            assign prev_gt_w    = cell_gt[i-1];
        end

        if (i == MAX_REQUESTS - 1) begin : g_tail
            assign next_key_w   = k0;
            assign next_valid_w = recirc;
        end else begin : g_body
            assign next_key_w   = cell_key[i+1];
            assign next_valid_w = cell_valid[i+1];
        end

        cscan_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (cell_ctl),
            .ins_key    (s_tdata[cscan_pkg::TRACK_BITS-1:0]),
            .prev_key   (prev_key_w),
            .prev_valid (prev_valid_w),
            .prev_gt    (prev_gt_w),
            .next_key   (next_key_w),
            .next_valid (next_valid_w),
            .key        (cell_key[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        cnt_next      = cnt_reg;
        left_next     = left_reg;
        ovf_next      = ovf_reg;
        end_done_next = end_done_reg;
        close_batch   = 1'b0;
        emit          = 1'b0;
        emit_jump     = 1'b0;
        emit_last     = 1'b0;
        emit_track    = k0;
        do_shift      = 1'b0;
        do_insert     = 1'b0;
        recirc        = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (req_reg < MAX_CNT) begin
                        do_insert = 1'b1;
                        req_next  = req_reg + CNT_ONE;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        close_batch   = 1'b1;
                        state_next    = ST_UP;
                        cnt_next      = '0;
                        left_next     = '0;
                        end_done_next = 1'b0;
                    end
                end
            end
            ST_UP: begin
                if (cnt_reg == MAX_CNT) begin
                    state_next = ST_END;
                end else if (!v0 || (k0 == head)) begin
                    do_shift = 1'b1;
                    cnt_next = cnt_reg + CNT_ONE;
                end else if (k0 < head) begin
                    do_shift  = 1'b1;
                    recirc    = 1'b1;
                    cnt_next  = cnt_reg + CNT_ONE;
                    left_next = left_reg + CNT_ONE;
                end else if (out_free) begin
                    emit = 1'b1;
                    if (!end_done_reg && (end_track <= k0)) begin
                        emit_track    = end_track;
                        end_done_next = 1'b1;
                    end else begin
                        do_shift = 1'b1;
                        cnt_next = cnt_reg + CNT_ONE;
                    end
                end
            end
            ST_END: begin
                if (end_done_reg) begin
                    state_next = ST_ZERO;
                end else if (out_free) begin
                    emit          = 1'b1;
                    emit_track    = end_track;
                    end_done_next = 1'b1;
                    state_next    = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_jump  = 1'b1;
                    emit_track = '0;
                    emit_last  = (left_reg == '0);
                    state_next = (left_reg == '0) ? ST_LOAD : ST_DOWN;
                end
            end
            ST_DOWN: begin
                if (!v0) begin
                    do_shift = 1'b1;
                end else if (out_free) begin
                    emit      = 1'b1;
                    do_shift  = 1'b1;
                    left_next = left_reg - CNT_ONE;
                    emit_last = (left_reg == CNT_ONE);
                    if (left_reg == CNT_ONE) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        if (emit && emit_last) begin
            req_next = '0;
            ovf_next = 1'b0;
        end
    end

    // Seek accumulation: the jump to track 0 costs the disk end track.
    assign seek_step = (emit_track >= pos_reg) ? (emit_track - pos_reg)
                                               : (pos_reg - emit_track);
    assign addend   = emit_jump ? end_track : seek_step;
    assign seek_sum = {1'b0, seek_reg} + (cscan_pkg::SEEK_BITS + 1)'(addend);
    assign seek_sat = seek_sum[cscan_pkg::SEEK_BITS] ? cscan_pkg::SEEK_MAX
                                                     : seek_sum[cscan_pkg::SEEK_BITS-1:0];

    always_comb begin
        pos_next  = pos_reg;
        seek_next = seek_reg;
        if (close_batch) begin
            pos_next  = head;
            seek_next = '0;
        end else if (emit) begin
            pos_next  = emit_track;
            seek_next = seek_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_size_reg  <= cscan_pkg::DISK_SIZE_RESET;
            start_head_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cscan_pkg::REG_DISK_SIZE: begin
                    disk_size_reg <= cfg_wdata;
                end
                cscan_pkg::REG_START_HEAD: begin
                    start_head_reg <= cfg_wdata[cscan_pkg::TRACK_BITS-1:0];
                end
                default: begin
                    disk_size_reg <= disk_size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            req_reg      <= '0;
            cnt_reg      <= '0;
            left_reg     <= '0;
            ovf_reg      <= 1'b0;
            end_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            req_reg      <= req_next;
            cnt_reg      <= cnt_next;
            left_reg     <= left_next;
            ovf_reg      <= ovf_next;
            end_done_reg <= end_done_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        seek_reg <= seek_next;
        if (emit) begin
            m_track_reg <= emit_track;
            m_seek_reg  <= seek_sat;
            m_ovf_reg   <= ovf_reg;
            m_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, m_seek_reg, m_track_reg};
    assign m_tuser  = m_ovf_reg;
    assign m_tlast  = m_last_reg;

    `CSCAN_ASSERT_SAME(a_req_bound, 1'b1, req_reg <= MAX_CNT, "Request count exceeds the row length.")
    `CSCAN_ASSERT_SAME(a_row_fill, state_reg == ST_LOAD, $countones(cell_valid) == int'(req_reg), "Occupied cells do not match the request count.")
    `CSCAN_ASSERT_NEXT(a_batch_done, emit && emit_last, (state_reg == ST_LOAD) && (req_reg == '0), "Batch not cleared after its final result.")
    `CSCAN_ASSERT_SAME(a_down_left, state_reg == ST_DOWN, left_reg != '0, "Draining with no lower tracks left.")

endmodule
